// ===== sv/lssf_pkg.sv =====
// shared types, kernel tables and helper functions for the smoothing filter
`timescale 1ns / 1ps

package lssf_pkg;

    // smoothing levels (half window width)
    localparam logic [1:0] LVL_3PT = 2'd1;
    localparam logic [1:0] LVL_5PT = 2'd2;
    localparam logic [1:0] LVL_7PT = 2'd3;

    // kernel kinds
    localparam logic [1:0] KIND_MID   = 2'd0;
    localparam logic [1:0] KIND_EDGE  = 2'd1;
    localparam logic [1:0] KIND_SHORT = 2'd2;

    // divisor codes
    localparam logic [2:0] DEN_3  = 3'd0;
    localparam logic [2:0] DEN_5  = 3'd1;
    localparam logic [2:0] DEN_6  = 3'd2;
    localparam logic [2:0] DEN_10 = 3'd3;
    localparam logic [2:0] DEN_21 = 3'd4;
    localparam logic [2:0] DEN_42 = 3'd5;

    // one kernel to apply to a window snapshot
    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] lvl;
        logic [1:0] offset;
        logic       at_end;
        logic       mark_last;
    } kern_t;

    // what travels with a result through the arithmetic stages
    typedef struct packed {
        logic [2:0] den_sel;
        logic       mark_last;
        logic       too_short;
    } res_tag_t;

    localparam logic signed [7:0] MID_TAPS [3][7] = '{
        '{1, 1, 1, 0, 0, 0, 0},
        '{1, 1, 1, 1, 1, 0, 0},
        '{-2, 3, 6, 7, 6, 3, -2}
    };

    localparam logic signed [7:0] EDGE_TAPS [3][3][7] = '{
        '{ '{5, 2, -1, 0, 0, 0, 0}, '{0, 0, 0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0, 0, 0} },
        '{ '{3, 2, 1, 0, -1, 0, 0}, '{4, 3, 2, 1, 0, 0, 0}, '{0, 0, 0, 0, 0, 0, 0} },
        '{ '{39, 8, -4, -4, 1, 4, -2}, '{8, 19, 16, 6, -4, -7, 4},
           '{-4, 16, 19, 12, 2, -4, 1} }
    };

    // coefficient applied to window position pos (0 is the newest sample)
    function automatic logic signed [7:0] kern_coef(kern_t kn, logic [2:0] pos);
        logic [2:0]        span;
        logic [2:0]        k;
        logic [1:0]        li;
        logic signed [7:0] c;
        span = {kn.lvl, 1'b0};
        li   = kn.lvl - 2'd1;
        k    = kn.at_end ? pos : (span - pos);
        c    = '0;
        if (pos <= span)
        begin
            case (kn.kind)
                KIND_MID:  c = MID_TAPS[li][pos];
                KIND_EDGE: c = EDGE_TAPS[li][kn.offset][k];
                default:   c = '0;
            endcase
        end
        return c;
    endfunction

    function automatic logic [2:0] kern_den_sel(kern_t kn);
        logic [2:0] sel;
        sel = DEN_6;
        case (kn.kind)
            KIND_MID:
            begin
                if (kn.lvl == LVL_3PT)
                    sel = DEN_3;
                else if (kn.lvl == LVL_5PT)
                    sel = DEN_5;
                else
                    sel = DEN_21;
            end
            KIND_EDGE:
            begin
                if (kn.lvl == LVL_3PT)
                    sel = DEN_6;
                else if (kn.lvl == LVL_5PT)
                    sel = (kn.offset == 2'd0) ? DEN_5 : DEN_10;
                else
                    sel = DEN_42;
            end
            default: sel = DEN_6;
        endcase
        return sel;
    endfunction

    function automatic logic [6:0] den_value(logic [2:0] sel);
        logic [6:0] v;
        case (sel)
            DEN_3:   v = 7'd3;
            DEN_5:   v = 7'd5;
            DEN_6:   v = 7'd6;
            DEN_10:  v = 7'd10;
            DEN_21:  v = 7'd21;
            DEN_42:  v = 7'd42;
            default: v = 7'd6;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/least_squares_smoothing_filter.sv =====
// top level of the least-squares smoothing filter
`timescale 1ns / 1ps

// least-squares smoothing filter, 3, 5 or 7 point window
// input channel: in_valid / in_stall with sample and is_last; is_last marks
//   the final sample of a series and flushes all pending results
// output channel: out_valid / out_stall with smoothed, last_out, too_short;
//   one result item per input sample, in order, last_out on the final one;
//   a series shorter than the window, or at levels 2 and 3 as long as it,
//   gives a single too_short item instead
// config: smoothing_level is written when smoothing_level_we is high; the
//   user must write it only while the block is idle, as the block has no
//   check for this; 0 acts as level 1
// throughput: one item per cycle unless out_stall holds a result; the
//   kernel scheduler issues one kernel per cycle into the tap/divide pipeline,
//   so an item with more than one result holds in_stall until the last issues
// reset: window cleared, series counter zero, level 1, pipeline empty
// stall: while out_stall holds a valid result the whole pipeline freezes and
//   the input stalls once the scheduler holds a pending item

module least_squares_smoothing_filter import lssf_pkg::*; #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          smoothing_level_we,
    input  logic [1:0]                    smoothing_level,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          is_last,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0] smoothed,
    output logic                          last_out,
    output logic                          too_short
);

    // pipeline advance: output register empty or being taken
    logic                          move;
    logic                          iss_valid;
    logic signed [SAMPLE_BITS-1:0] iss_win [7];
    kern_t                         iss_kern;
    logic                          sum_valid;
    logic signed [SAMPLE_BITS+7:0] sum_val;
    res_tag_t                      sum_tag;

    assign move = !out_valid || !out_stall;

    // window, counter and kernel list per item
    lssf_sched #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_sched (
        .clk                (clk),
        .rst_n              (rst_n),
        .smoothing_level_we (smoothing_level_we),
        .smoothing_level    (smoothing_level),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .sample             (sample),
        .is_last            (is_last),
        .move               (move),
        .iss_valid          (iss_valid),
        .iss_win            (iss_win),
        .iss_kern           (iss_kern)
    );

    // tap products and sum
    lssf_taps #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_taps (
        .clk       (clk),
        .rst_n     (rst_n),
        .move      (move),
        .iss_valid (iss_valid),
        .iss_win   (iss_win),
        .iss_kern  (iss_kern),
        .sum_valid (sum_valid),
        .sum_val   (sum_val),
        .sum_tag   (sum_tag)
    );

    // rounding division, saturation, output register
    lssf_div #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .move      (move),
        .sum_valid (sum_valid),
        .sum_val   (sum_val),
        .sum_tag   (sum_tag),
        .out_valid (out_valid),
        .smoothed  (smoothed),
        .last_out  (last_out),
        .too_short (too_short)
    );

endmodule

// ===== sv/lssf_sched.sv =====
// sample window, series counter, level register and per-item kernel scheduler
`timescale 1ns / 1ps

module lssf_sched import lssf_pkg::*; #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          smoothing_level_we,
    input  logic [1:0]                    smoothing_level,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          is_last,
    input  logic                          move,
    output logic                          iss_valid,
    output logic signed [SAMPLE_BITS-1:0] iss_win [7],
    output kern_t                         iss_kern
);

    logic [1:0]                    lvl_reg;
    logic [2:0]                    idx_reg;
    logic [2:0]                    idx_next;
    logic signed [SAMPLE_BITS-1:0] win_reg [7];
    logic signed [SAMPLE_BITS-1:0] win_next [7];

    logic                          job_valid_reg;
    logic signed [SAMPLE_BITS-1:0] job_win_reg [7];
    kern_t                         job_kern_reg [4];
    logic [2:0]                    job_cnt_reg;
    logic [1:0]                    job_pos_reg;

    kern_t      list_next [4];
    logic [2:0] list_cnt;
    logic [2:0] last_pos;
    logic [2:0] span;
    logic       is_short;
    logic       do_start;
    logic       do_mid;
    logic       do_end;
    logic       issue;
    logic       job_final;
    logic       job_free;
    logic       accept;

    assign issue     = move && job_valid_reg;
    assign job_final = ({1'b0, job_pos_reg} == (job_cnt_reg - 3'd1));
    assign job_free  = !job_valid_reg || (issue && job_final);
    assign in_stall  = !job_free;
    assign accept    = in_valid && job_free;

    assign iss_valid = job_valid_reg;
    assign iss_win   = job_win_reg;
    assign iss_kern  = job_kern_reg[job_pos_reg];

    always_comb
    begin
        win_next[0] = sample;
        for (int p = 1; p < 7; p++)
            win_next[p] = win_reg[p-1];
    end

    assign idx_next = is_last ? 3'd0 : ((idx_reg < 3'd7) ? idx_reg + 3'd1 : 3'd7);

    // which kernels this item releases
    assign span     = {lvl_reg, 1'b0};
    assign is_short = is_last && ((idx_reg < span) || ((idx_reg == span) && (lvl_reg >= LVL_5PT)));
    assign do_start = !is_short && (idx_reg == span);
    assign do_mid   = !is_short && (idx_reg >= span);
    assign do_end   = !is_short && is_last;

    always_comb
    begin
        for (int s = 0; s < 4; s++)
            list_next[s] = '0;
        list_cnt = 3'd0;
        if (is_short)
        begin
            list_next[0] = '{kind: KIND_SHORT, lvl: LVL_3PT, offset: 2'd0,
                             at_end: 1'b0, mark_last: 1'b1};
            list_cnt = 3'd1;
        end
        for (int d = 0; d < 3; d++)
        begin
            if (do_start && (2'(d) < lvl_reg))
            begin
                list_next[list_cnt[1:0]] = '{kind: KIND_EDGE, lvl: lvl_reg, offset: 2'(d),
                                             at_end: 1'b0, mark_last: 1'b0};
                list_cnt = list_cnt + 3'd1;
            end
        end
        if (do_mid)
        begin
            list_next[list_cnt[1:0]] = '{kind: KIND_MID, lvl: lvl_reg, offset: 2'd0,
                                         at_end: 1'b0, mark_last: 1'b0};
            list_cnt = list_cnt + 3'd1;
        end
        for (int d = 2; d >= 0; d--)
        begin
            if (do_end && (2'(d) < lvl_reg))
            begin
                list_next[list_cnt[1:0]] = '{kind: KIND_EDGE, lvl: lvl_reg, offset: 2'(d),
                                             at_end: 1'b1, mark_last: 1'b0};
                list_cnt = list_cnt + 3'd1;
            end
        end
        last_pos = list_cnt - 3'd1;
        if (do_end)
            list_next[last_pos[1:0]].mark_last = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lvl_reg       <= LVL_3PT;
            idx_reg       <= 3'd0;
            job_valid_reg <= 1'b0;
            job_pos_reg   <= 2'd0;
            for (int p = 0; p < 7; p++)
                win_reg[p] <= '0;
        end
        else
        begin
            // level zero behaves as the three-point level
            if (smoothing_level_we)
                lvl_reg <= (smoothing_level == 2'd0) ? LVL_3PT : smoothing_level;
            if (accept)
            begin
                win_reg <= win_next;
                idx_reg <= idx_next;
            end
            if (accept && (list_cnt != 3'd0))
            begin
                job_valid_reg <= 1'b1;
                job_pos_reg   <= 2'd0;
            end
            else if (issue)
            begin
                if (job_final)
                    job_valid_reg <= 1'b0;
                else
                    job_pos_reg <= job_pos_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            job_win_reg  <= win_next;
            job_kern_reg <= list_next;
            job_cnt_reg  <= list_cnt;
        end
    end

endmodule

// ===== sv/lssf_taps.sv =====
// tap products and window sum for one kernel per cycle while move is high
`timescale 1ns / 1ps

module lssf_taps import lssf_pkg::*; #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            move,
    input  logic                            iss_valid,
    input  logic signed [SAMPLE_BITS-1:0]   iss_win [7],
    input  kern_t                           iss_kern,
    output logic                            sum_valid,
    output logic signed [SAMPLE_BITS+7:0]   sum_val,
    output res_tag_t                        sum_tag
);

    localparam int PROD_W = SAMPLE_BITS + 8;

    logic signed [7:0]        coef [7];
    logic signed [PROD_W-1:0] prod_next [7];
    logic signed [PROD_W-1:0] prod_reg [7];
    logic signed [PROD_W-1:0] acc;
    res_tag_t                 tag_next;
    res_tag_t                 tag1_reg;
    res_tag_t                 tag2_reg;
    logic                     v1_reg;
    logic                     v2_reg;
    logic signed [PROD_W-1:0] sum_reg;

    always_comb
    begin
        for (int p = 0; p < 7; p++)
        begin
            coef[p]      = kern_coef(iss_kern, 3'(p));
            prod_next[p] = PROD_W'(iss_win[p]) * PROD_W'(coef[p]);
        end
    end

    assign tag_next = '{den_sel: kern_den_sel(iss_kern), mark_last: iss_kern.mark_last,
                        too_short: (iss_kern.kind == KIND_SHORT)};

    always_comb
    begin
        acc = '0;
        for (int p = 0; p < 7; p++)
            acc = acc + prod_reg[p];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (move)
        begin
            v1_reg <= iss_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            prod_reg <= prod_next;
            tag1_reg <= tag_next;
            sum_reg  <= acc;
            tag2_reg <= tag1_reg;
        end
    end

    assign sum_valid = v2_reg;
    assign sum_val   = sum_reg;
    assign sum_tag   = tag2_reg;

endmodule

// ===== sv/lssf_div.sv =====
// rounding division by the kernel divisor, saturation and result register
`timescale 1ns / 1ps

module lssf_div import lssf_pkg::*; #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          move,
    input  logic                          sum_valid,
    input  logic signed [SAMPLE_BITS+7:0] sum_val,
    input  res_tag_t                      sum_tag,
    output logic                          out_valid,
    output logic signed [SAMPLE_BITS-1:0] smoothed,
    output logic                          last_out,
    output logic                          too_short
);

    localparam int NUM_W = SAMPLE_BITS + 8;
    localparam int M     = SAMPLE_BITS + 7;
    localparam int H     = (M + 1) / 2;
    localparam int HW    = M - H;

    // floor(2^M / (2 * den)), off by at most one below the true quotient
    localparam logic [M-1:0] RECIP_3  = M'((64'd1 << M) / 64'd6);
    localparam logic [M-1:0] RECIP_5  = M'((64'd1 << M) / 64'd10);
    localparam logic [M-1:0] RECIP_6  = M'((64'd1 << M) / 64'd12);
    localparam logic [M-1:0] RECIP_10 = M'((64'd1 << M) / 64'd20);
    localparam logic [M-1:0] RECIP_21 = M'((64'd1 << M) / 64'd42);
    localparam logic [M-1:0] RECIP_42 = M'((64'd1 << M) / 64'd84);

    localparam logic [M-1:0] LIM_POS = (M'(1) << (SAMPLE_BITS - 1)) - M'(1);
    localparam logic [M-1:0] LIM_NEG = M'(1) << (SAMPLE_BITS - 1);
    localparam logic [SAMPLE_BITS-1:0] MAX_POS = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] MIN_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // magnitude stage
    logic             neg_s3;
    logic [NUM_W-1:0] mag_full;
    logic [M-1:0]     m2_next;
    logic             v3_reg;
    logic [M-1:0]     m2_3_reg;
    logic             neg3_reg;
    res_tag_t         tag3_reg;

    // partial product stage
    logic [M-1:0]      recip;
    logic              v4_reg;
    logic [2*H-1:0]    pp_ll_reg;
    logic [M-1:0]      pp_lh_reg;
    logic [M-1:0]      pp_hl_reg;
    logic [2*HW-1:0]   pp_hh_reg;
    logic [M-1:0]      m2_4_reg;
    logic              neg4_reg;
    res_tag_t          tag4_reg;

    // quotient estimate stage
    logic [2*M-1:0] full;
    logic           v5_reg;
    logic [M-1:0]   q0_reg;
    logic [M-1:0]   m2_5_reg;
    logic           neg5_reg;
    res_tag_t       tag5_reg;

    // correction and saturation
    logic [7:0]             d2;
    logic [M+7:0]           qd;
    logic [M-1:0]           rem;
    logic [M-1:0]           q;
    logic [M-1:0]           neg_q;
    logic [SAMPLE_BITS-1:0] sm_next;
    logic                   out_valid_reg;
    logic [SAMPLE_BITS-1:0] smoothed_reg;
    logic                   last_reg;
    logic                   short_reg;

    assign neg_s3   = sum_val[NUM_W-1];
    assign mag_full = neg_s3 ? (NUM_W'(0) - NUM_W'(sum_val)) : NUM_W'(sum_val);
    assign m2_next  = {mag_full[M-2:0], 1'b0} + M'(den_value(sum_tag.den_sel));

    always_comb
    begin
        case (tag3_reg.den_sel)
            DEN_3:   recip = RECIP_3;
            DEN_5:   recip = RECIP_5;
            DEN_6:   recip = RECIP_6;
            DEN_10:  recip = RECIP_10;
            DEN_21:  recip = RECIP_21;
            DEN_42:  recip = RECIP_42;
            default: recip = RECIP_6;
        endcase
    end

    assign full = (2*M)'(pp_ll_reg)
                + ((2*M)'(pp_lh_reg) << H)
                + ((2*M)'(pp_hl_reg) << H)
                + ((2*M)'(pp_hh_reg) << (2*H));

    assign d2    = {den_value(tag5_reg.den_sel), 1'b0};
    assign qd    = (M+8)'(q0_reg) * (M+8)'(d2);
    assign rem   = m2_5_reg - qd[M-1:0];
    assign q     = (rem >= M'(d2)) ? (q0_reg + M'(1)) : q0_reg;
    assign neg_q = ~q + M'(1);

    always_comb
    begin
        if (neg5_reg)
            sm_next = (q > LIM_NEG) ? MIN_NEG : neg_q[SAMPLE_BITS-1:0];
        else
            sm_next = (q > LIM_POS) ? MAX_POS : q[SAMPLE_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (move)
        begin
            v3_reg        <= sum_valid;
            v4_reg        <= v3_reg;
            v5_reg        <= v4_reg;
            out_valid_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            m2_3_reg <= m2_next;
            neg3_reg <= neg_s3;
            tag3_reg <= sum_tag;

            pp_ll_reg <= (2*H)'(m2_3_reg[H-1:0]) * (2*H)'(recip[H-1:0]);
            pp_lh_reg <= M'(m2_3_reg[H-1:0]) * M'(recip[M-1:H]);
            pp_hl_reg <= M'(m2_3_reg[M-1:H]) * M'(recip[H-1:0]);
            pp_hh_reg <= (2*HW)'(m2_3_reg[M-1:H]) * (2*HW)'(recip[M-1:H]);
            m2_4_reg  <= m2_3_reg;
            neg4_reg  <= neg3_reg;
            tag4_reg  <= tag3_reg;

            q0_reg   <= full[2*M-1:M];
            m2_5_reg <= m2_4_reg;
            neg5_reg <= neg4_reg;
            tag5_reg <= tag4_reg;

            smoothed_reg <= sm_next;
            last_reg     <= tag5_reg.mark_last;
            short_reg    <= tag5_reg.too_short;
        end
    end

    assign out_valid = out_valid_reg;
    assign smoothed  = smoothed_reg;
    assign last_out  = last_reg;
    assign too_short = short_reg;

endmodule

// ===== sv/lssf_checker.sv =====
// port-level assertions for the smoothing filter and their bind
`timescale 1ns / 1ps

module lssf_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic signed [SAMPLE_BITS-1:0] sample,
    input logic                          is_last,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic signed [SAMPLE_BITS-1:0] smoothed,
    input logic                          last_out,
    input logic                          too_short
);

    a_in_stable: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(sample) && $stable(is_last))
        else $error("stalled input item changed");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result item dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(smoothed) && $stable(last_out) && $stable(too_short))
        else $error("stalled result item changed");

    a_short_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && too_short |-> last_out)
        else $error("short series item not marked last");

    a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && too_short |-> (smoothed == '0))
        else $error("short series item carries a value");

endmodule

bind least_squares_smoothing_filter lssf_checker #(
    .SAMPLE_BITS(SAMPLE_BITS)
) u_lssf_checker (.*);

// ===== test/tb_least_squares_smoothing_filter.sv =====
// self-checking testbench for the least-squares smoothing filter
`timescale 1ns / 1ps

module tb_least_squares_smoothing_filter;

    import lssf_pkg::LVL_3PT;
    import lssf_pkg::LVL_5PT;
    import lssf_pkg::LVL_7PT;

    // register value 0 behaves as the 3-point level
    localparam logic [1:0] LVL_ZERO_AS_3PT = 2'd0;

    localparam int DRAIN_CYCLES = 16;   // covers the pipeline depth plus margin
    localparam int LONG_HOLD    = 120;  // receiver hold-off for the backpressure test
    localparam int RANDOM_ITEMS = 140;

    // expected output item
    typedef struct packed {
        logic signed [15:0] value;
        logic               last;
        logic               flagged;
    } smooth_res_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               smoothing_level_we = 1'b0;
    logic [1:0]         smoothing_level = 2'd0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic signed [15:0] sample = '0;
    logic               is_last = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [15:0] smoothed;
    logic               last_out;
    logic               too_short;

    // predictor state: newest sample at index 0
    logic signed [15:0] sample_hist [0:6];
    logic [2:0]         series_pos;
    logic [1:0]         active_level;
    smooth_res_t        expected_smoothed [$];

    // sender shaping
    bit   gaps_on;
    int   burst_left;

    // receiver shaping
    int   hold_requests;
    int   hold_served;
    int   hold_left;
    int   stall_run;
    int   rx_mode;
    int   frame_left;

    // bookkeeping
    int       mismatches;
    int       results_checked;
    int       samples_sent;
    int       series_sent;
    int       in_stall_cycles;
    logic [3:0] levels_used;

    least_squares_smoothing_filter #(
        .SAMPLE_BITS(16)
    ) u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .smoothing_level_we(smoothing_level_we),
        .smoothing_level   (smoothing_level),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .sample            (sample),
        .is_last           (is_last),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .smoothed          (smoothed),
        .last_out          (last_out),
        .too_short         (too_short)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // kernel taps packed as 8-bit signed values, tap 0 in the low byte
    function automatic logic [55:0] tap_row(int h, bit at_border, int d);
        logic [55:0] r;
        r = '0;
        if (!at_border)
        begin
            case (h)
                1:       r = {8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd1, 8'sd1, 8'sd1};
                2:       r = {8'sd0, 8'sd0, 8'sd1, 8'sd1, 8'sd1, 8'sd1, 8'sd1};
                default: r = {-8'sd2, 8'sd3, 8'sd6, 8'sd7, 8'sd6, 8'sd3, -8'sd2};
            endcase
        end
        else
        begin
            case (h * 4 + d)
                4:       r = {8'sd0, 8'sd0, 8'sd0, 8'sd0, -8'sd1, 8'sd2, 8'sd5};
                8:       r = {8'sd0, 8'sd0, -8'sd1, 8'sd0, 8'sd1, 8'sd2, 8'sd3};
                9:       r = {8'sd0, 8'sd0, 8'sd0, 8'sd1, 8'sd2, 8'sd3, 8'sd4};
                12:      r = {-8'sd2, 8'sd4, 8'sd1, -8'sd4, -8'sd4, 8'sd8, 8'sd39};
                13:      r = {8'sd4, -8'sd7, -8'sd4, 8'sd6, 8'sd16, 8'sd19, 8'sd8};
                default: r = {8'sd1, -8'sd4, 8'sd2, 8'sd12, 8'sd19, 8'sd16, -8'sd4};
            endcase
        end
        return r;
    endfunction

    function automatic int tap_div(int h, bit at_border, int d);
        int v;
        if (!at_border)
            v = (h == 1) ? 3 : ((h == 2) ? 5 : 21);
        else if (h == 1)
            v = 6;
        else if (h == 2)
            v = (d == 0) ? 5 : 10;
        else
            v = 42;
        return v;
    endfunction

    // weighted sum over the 2h+1 newest samples, rounded half away from zero
    // and clamped to the 16-bit range; from_start flips the kernel so that
    // tap 0 lands on the oldest sample of the window
    function automatic logic signed [15:0] kernel_out(logic [55:0] row, int den, int h,
                                                      bit from_start);
        longint             acc;
        longint             mag;
        longint             q;
        logic signed [7:0]  c;
        logic signed [15:0] r;
        int                 k;
        int                 pos;
        bit                 neg;
        acc = 0;
        for (k = 0; k <= 2 * h; k++)
        begin
            pos = from_start ? (2 * h - k) : k;
            c   = row[8 * k +: 8];
            acc = acc + longint'(c) * longint'(sample_hist[pos]);
        end
        neg = acc < 0;
        mag = neg ? -acc : acc;
        q   = (mag * 2 + den) / (2 * longint'(den));
        if (neg)
        begin
            if (q > 32768)
                q = 32768;
            r = 16'(-q);
        end
        else
        begin
            if (q > 32767)
                q = 32767;
            r = 16'(q);
        end
        return r;
    endfunction

    task automatic add_expected(input logic signed [15:0] v, input logic l, input logic f);
        expected_smoothed.push_back(smooth_res_t'{v, l, f});
    endtask

    // advance the predictor by one accepted item and queue its results
    task automatic predict_smoothing(input logic signed [15:0] x, input logic last);
        int h;
        int idx;
        int d;
        h   = (active_level == LVL_ZERO_AS_3PT) ? 1 : int'(active_level);
        idx = int'(series_pos);
        for (d = 6; d > 0; d--)
            sample_hist[d] = sample_hist[d - 1];
        sample_hist[0] = x;
        series_pos = last ? 3'd0 : ((idx < 7) ? 3'(idx + 1) : 3'd7);
        // too short for the window, or a full window that would need more
        // than four results at the wider levels: one flagged result
        if (last && (idx < 2 * h || (idx == 2 * h && h >= 2)))
            add_expected(16'sd0, 1'b1, 1'b1);
        else
        begin
            if (idx == 2 * h)
                for (d = 0; d < h; d++)
                    add_expected(kernel_out(tap_row(h, 1'b1, d), tap_div(h, 1'b1, d), h, 1'b1),
                                 1'b0, 1'b0);
            if (idx >= 2 * h)
                add_expected(kernel_out(tap_row(h, 1'b0, 0), tap_div(h, 1'b0, 0), h, 1'b0),
                             1'b0, 1'b0);
            if (last)
                for (d = h - 1; d >= 0; d--)
                    add_expected(kernel_out(tap_row(h, 1'b1, d), tap_div(h, 1'b1, d), h, 1'b0),
                                 d == 0, 1'b0);
        end
    endtask

    // offer one item, keep it steady until accepted, then predict
    task automatic push_sample(input logic signed [15:0] value, input logic last);
        int gap;
        if (gaps_on && burst_left == 0)
        begin
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 10);
        end
        if (burst_left > 0)
            burst_left--;
        in_valid <= 1'b1;
        sample   <= value;
        is_last  <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_smoothing(value, last);
        samples_sent++;
        if (last)
            series_sent++;
    endtask

    // stop offering, wait for every expected item, then let the pipe settle
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_smoothed.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_level(input logic [1:0] lvl);
        smoothing_level_we <= 1'b1;
        smoothing_level    <= lvl;
        @(posedge clk);
        smoothing_level_we <= 1'b0;
        active_level = lvl;
        levels_used[lvl] = 1'b1;
    endtask

    function automatic logic [15:0] pick_sample();
        logic [15:0] v;
        case ($urandom_range(0, 9))
            0:       v = 16'h7fff;
            1:       v = 16'h8000;
            2:       v = 16'($urandom_range(0, 20) - 10);
            default: v = 16'($urandom);
        endcase
        return v;
    endfunction

    task automatic push_series(input int len);
        int i;
        for (i = 0; i < len; i++)
            push_sample(pick_sample(), i == len - 1);
    endtask

    // 3-point mean at the reset level: full-scale extremes and a one-item series
    task automatic test_level1_extremes();
        push_sample(16'sh7fff, 1'b0);
        push_sample(-16'sh8000, 1'b0);
        push_sample(16'sh7fff, 1'b1);
        push_sample(-16'sh8000, 1'b1);
        drain_results();
    endtask

    task automatic test_level_zero();
        write_level(LVL_ZERO_AS_3PT);
        push_sample(16'sd12345, 1'b0);
        push_sample(-16'sd1, 1'b0);
        push_sample(16'sd0, 1'b0);
        push_sample(16'sd7, 1'b1);
        drain_results();
    endtask

    // five samples at the 5-point level come back as one flagged item
    task automatic test_exact_window_5pt();
        int i;
        write_level(LVL_5PT);
        for (i = 0; i < 5; i++)
            push_sample((i % 2) ? -16'sh8000 : 16'sh7fff, i == 4);
        drain_results();
    endtask

    task automatic test_7pt_saturation();
        write_level(LVL_7PT);
        push_sample(16'sh7fff, 1'b0);
        push_sample(16'sh7fff, 1'b0);
        push_sample(-16'sh8000, 1'b0);
        push_sample(16'sh7fff, 1'b0);
        push_sample(16'sh7fff, 1'b0);
        push_sample(-16'sh8000, 1'b0);
        push_sample(-16'sh8000, 1'b0);
        push_sample(16'sh7fff, 1'b1);
        drain_results();
    endtask

    // start a series at the 7-point level, narrow to 3 points before any result
    task automatic test_level_switch_mid_series();
        write_level(LVL_7PT);
        push_sample(16'sd1000, 1'b0);
        push_sample(-16'sd3000, 1'b0);
        drain_results();
        write_level(LVL_3PT);
        push_sample(16'sh7fff, 1'b0);
        push_sample(-16'sh8000, 1'b1);
        drain_results();
    endtask

    // receiver holds off for a long stretch while a long series keeps coming
    task automatic test_backpressure();
        write_level(LVL_7PT);
        gaps_on = 1'b0;
        hold_requests <= hold_requests + 1;
        push_series(40);
        drain_results();
    endtask

    // mostly well-formed series with random content, some short ones,
    // level rewritten between series while the block is idle
    task automatic test_random_series();
        int start;
        int h;
        int len;
        start = samples_sent;
        while (samples_sent - start < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 9) < 4)
            begin
                drain_results();
                write_level(2'($urandom_range(0, 3)));
            end
            gaps_on = $urandom_range(0, 3) != 0;
            h = (active_level == LVL_ZERO_AS_3PT) ? 1 : int'(active_level);
            if ($urandom_range(0, 4) == 0)
                len = $urandom_range(1, 2 * h + 1);
            else
                len = $urandom_range(2 * h + 2, 14);
            push_series(len);
        end
        drain_results();
    endtask

    // output side: check accepted items
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_stall)
                in_stall_cycles++;
            if (out_valid && !out_stall)
            begin
                results_checked++;
                if (expected_smoothed.size() == 0)
                begin
                    mismatches++;
                    $display("%0t ns: item %0d arrived with nothing expected, actual %0d",
                             $time, results_checked, smoothed);
                end
                else
                begin
                    smooth_res_t want;
                    want = expected_smoothed.pop_front();
                    if (smoothed !== want.value)
                    begin
                        mismatches++;
                        $display("%0t ns: smoothed expected %0d actual %0d",
                                 $time, want.value, smoothed);
                    end
                    if (last_out !== want.last)
                    begin
                        mismatches++;
                        $display("%0t ns: last_out expected %0b actual %0b",
                                 $time, want.last, last_out);
                    end
                    if (too_short !== want.flagged)
                    begin
                        mismatches++;
                        $display("%0t ns: too_short expected %0b actual %0b",
                                 $time, want.flagged, too_short);
                    end
                end
            end
        end
    end

    // receiver: long hold-off on request, otherwise its own stall pattern
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (frame_left == 0)
            begin
                rx_mode    = $urandom_range(0, 2);
                frame_left = $urandom_range(16, 64);
            end
            else
                frame_left--;
            if (hold_served != hold_requests)
            begin
                hold_served = hold_requests;
                hold_left   = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (stall_run > 0)
            begin
                stall_run--;
                out_stall <= 1'b1;
            end
            else if (rx_mode == 1 && $urandom_range(0, 3) == 0)
            begin
                stall_run = $urandom_range(0, 2);
                out_stall <= 1'b1;
            end
            else if (rx_mode == 2 && $urandom_range(0, 1) == 0)
            begin
                stall_run = $urandom_range(0, 4);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin
        foreach (sample_hist[i])
            sample_hist[i] = '0;
        series_pos      = 3'd0;
        active_level    = LVL_3PT;
        levels_used     = 4'b0010;
        gaps_on         = 1'b0;
        burst_left      = 0;
        hold_requests   = 0;
        hold_served     = 0;
        hold_left       = 0;
        stall_run       = 0;
        rx_mode         = 0;
        frame_left      = 0;
        mismatches      = 0;
        results_checked = 0;
        samples_sent    = 0;
        series_sent     = 0;
        in_stall_cycles = 0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_level1_extremes();
        test_level_zero();
        test_exact_window_5pt();
        test_7pt_saturation();
        test_level_switch_mid_series();
        test_backpressure();
        test_random_series();
        drain_results();

        $display("covered %0d samples in %0d series, level codes used %b, %0d items checked",
                 samples_sent, series_sent, levels_used, results_checked);
        $display("input offered but held off for %0d cycles", in_stall_cycles);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // run limit, far beyond the slowest legal run
    initial
    begin
        #2000000;
        $display("FAIL");
        $finish;
    end

endmodule
